### sv/arm_forward_kinematics_6dof_top_assert.svh
// ----------------------------------------------------------------------------
// arm forward kinematics assertion macros
// concurrent checks on the rising clock edge, removed for synthesis
// ----------------------------------------------------------------------------
`ifndef ARM_FORWARD_KINEMATICS_6DOF_TOP_ASSERT_SVH
`define ARM_FORWARD_KINEMATICS_6DOF_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// checked outside reset only
`define ARMFK_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("armfk check failed");
// checked during reset too
`define ARMFK_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("armfk check failed");
`else
`define ARMFK_ASSERT(lbl, prop)
`define ARMFK_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

### sv/armfk_pkg.sv
// ----------------------------------------------------------------------------
// armfk_pkg
// shared types, constants and arithmetic helpers of the arm kinematics block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package armfk_pkg;

  localparam int CordicStagesDef = 18;
  localparam int AtanEntries     = 24;
  localparam int RedSteps        = 4;
  localparam int AngW            = 22;
  localparam int ZW              = 38;
  localparam int CordW           = 34;
  localparam int LenW            = 18;
  localparam int PosW            = 58;
  localparam int WideW           = 35;
  localparam int KinLat          = 5;
  localparam int SinCosExtra     = 7;

  typedef logic signed [CordW-1:0] trig_t;
  typedef logic signed [LenW-1:0]  len_t;
  typedef logic signed [PosW-1:0]  pos_t;
  typedef logic signed [WideW-1:0] wide_t;
  typedef logic signed [ZW-1:0]    zang_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    RegBaseHeight,
    RegUpperArm,
    RegForearm,
    RegWrist1,
    RegWrist2,
    RegWrist3
  } cfg_reg_e;

  // trig channel slots
  localparam int TrigQ1   = 0;
  localparam int TrigQ2   = 1;
  localparam int TrigQ3   = 2;
  localparam int TrigQ5   = 3;
  localparam int TrigQ6   = 4;
  localparam int TrigQ234 = 5;
  localparam int TrigN    = 6;

  localparam zang_t Q30Pi     = 38'sd3373259426;
  localparam zang_t Q30HalfPi = 38'sd1686629713;
  localparam zang_t Q30TwoPi  = 38'sd6746518852;
  localparam trig_t Q30Gain   = 34'sd652032874;

  localparam trig_t AtanQ30 [AtanEntries] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
    34'sd67021687, 34'sd33543516, 34'sd16775851, 34'sd8388437,
    34'sd4194283, 34'sd2097149, 34'sd1048576, 34'sd524288,
    34'sd262144, 34'sd131072, 34'sd65536, 34'sd32768,
    34'sd16384, 34'sd8192, 34'sd4096, 34'sd2048,
    34'sd1024, 34'sd512, 34'sd256, 34'sd128
  };

  typedef struct packed {
    trig_t x;
    trig_t y;
    trig_t z;
    logic  neg;
  } cord_t;

  // one conditional wrap by a full turn
  function automatic zang_t reduce_step(zang_t z);
    zang_t r;
    r = z;
    if (z > Q30Pi) begin
      r = z - Q30TwoPi;
    end else if (z < -Q30Pi) begin
      r = z + Q30TwoPi;
    end
    return r;
  endfunction

  // Q.30 product, rounded half up
  function automatic trig_t mul30(trig_t a, trig_t b);
    logic signed [2*CordW-1:0] p;
    p = a * b + 68'sd536870912;
    return p[CordW+29:30];
  endfunction

  // length times trig value, Q.46
  function automatic pos_t lmul(len_t d, trig_t t);
    logic signed [LenW+CordW-1:0] p;
    p = d * t;
    return pos_t'(p);
  endfunction

  // Q.30 to Q.16 rotation entry with saturation
  function automatic logic signed [17:0] rot_round(wide_t v);
    wide_t r;
    r = (v + 35'sd8192) >>> 14;
    if (r > 35'sd65536) begin
      return 18'sd65536;
    end else if (r < -35'sd65536) begin
      return -18'sd65536;
    end
    return r[17:0];
  endfunction

  // Q.46 to Q.16 position with saturation
  function automatic logic signed [19:0] pos_round(pos_t v);
    pos_t r;
    r = (v + 58'sd536870912) >>> 30;
    if (r > 58'sd262144) begin
      return 20'sd262144;
    end else if (r < -58'sd262144) begin
      return -20'sd262144;
    end
    return r[19:0];
  endfunction

endpackage

### sv/armfk_cordic_cell.sv
// ----------------------------------------------------------------------------
// armfk_cordic_cell
// one rotation-mode cordic micro-rotation, registered
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module armfk_cordic_cell import armfk_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic  clk_i,
  input  logic  en_i,
  input  cord_t cord_i,
  output cord_t cord_o
);

  cord_t cord_d, cord_q;

  // rotate toward zero residual angle
  always_comb begin
    cord_d = cord_i;
    if (cord_i.z >= 0) begin
      cord_d.x = cord_i.x - (cord_i.y >>> STAGE);
      cord_d.y = cord_i.y + (cord_i.x >>> STAGE);
      cord_d.z = cord_i.z - AtanQ30[STAGE];
    end else begin
      cord_d.x = cord_i.x + (cord_i.y >>> STAGE);
      cord_d.y = cord_i.y - (cord_i.x >>> STAGE);
      cord_d.z = cord_i.z + AtanQ30[STAGE];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cord_q <= cord_d;
    end
  end

  assign cord_o = cord_q;

endmodule

### sv/armfk_sincos.sv
// ----------------------------------------------------------------------------
// armfk_sincos
// angle wrap, quadrant fold and a row of cordic cells giving sin and cos
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module armfk_sincos import armfk_pkg::*; #(
  parameter int CORDIC_STAGES = CordicStagesDef
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [AngW-1:0] angle_i,
  output trig_t                  sin_o,
  output trig_t                  cos_o
);

  zang_t red_q [RedSteps+1];
  cord_t cord  [CORDIC_STAGES+1];
  cord_t fold_d;
  trig_t sin_q, cos_q;

  // scale Q5.16 to Q.30
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      red_q[0] <= zang_t'(angle_i) <<< 14;
    end
  end

  // wrap into one turn, one step per stage
  for (genvar k = 0; k < RedSteps; k++) begin : g_red
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        red_q[k+1] <= reduce_step(red_q[k]);
      end
    end
  end

  // fold into the right half plane
  always_comb begin
    zang_t zf;
    zf         = red_q[RedSteps];
    fold_d.neg = 1'b0;
    if (red_q[RedSteps] > Q30HalfPi) begin
      zf         = red_q[RedSteps] - Q30Pi;
      fold_d.neg = 1'b1;
    end else if (red_q[RedSteps] < -Q30HalfPi) begin
      zf         = red_q[RedSteps] + Q30Pi;
      fold_d.neg = 1'b1;
    end
    fold_d.x = Q30Gain;
    fold_d.y = '0;
    fold_d.z = zf[CordW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cord[0] <= fold_d;
    end
  end

  // cordic cell row
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    armfk_cordic_cell #(
      .STAGE(i)
    ) u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .cord_i(cord[i]),
      .cord_o(cord[i+1])
    );
  end

  // undo the fold
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= cord[CORDIC_STAGES].neg ? -cord[CORDIC_STAGES].y : cord[CORDIC_STAGES].y;
      cos_q <= cord[CORDIC_STAGES].neg ? -cord[CORDIC_STAGES].x : cord[CORDIC_STAGES].x;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

### sv/armfk_kin.sv
// ----------------------------------------------------------------------------
// armfk_kin
// closed-form product and sum pipeline from trig values to pose
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module armfk_kin import armfk_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  trig_t            sin_i [TrigN],
  input  trig_t            cos_i [TrigN],
  input  len_t             d1_i,
  input  len_t             a2_i,
  input  len_t             a3_i,
  input  len_t             d4_i,
  input  len_t             d5_i,
  input  len_t             d6_i,
  output logic signed [17:0] rot_o [9],
  output logic signed [19:0] pos_o [3]
);

  trig_t s1, c1, s2, c2, s3, c3, s5, c5, s6, c6, s234, c234;

  // stage 1
  trig_t c2c3_q, s2s3_q, s2c3_q, c2s3_q, c1s234_q, s1s234_q, c234s5_q, s1s5_q;
  trig_t c1c234_q, s1c234_q, c1s5_q, c5s1_q, c1c5_q, s234s5_q, c234s6_q, c234c6_q;
  trig_t s234c5_q, c1c2_q, s1c2_q, c1_1q, s1_1q, c5_1q, c6_1q, s6_1q;
  pos_t  px1_q, py1_q, pz1_q;
  // stage 2
  trig_t c23_q, s23_q, ub_q, va_q, c1c234s5_q, s1c234s5_q;
  trig_t c6c1s234_q, s6c1s234_q, c6s1s234_q, s6s1s234_q, s234c5c6_q, s234c5s6_q;
  trig_t s1s5_2q, c1s5_2q, c6_2q, s6_2q, c1_2q, s1_2q, c5s1_2q, c1c5_2q;
  trig_t s234s5_2q, c234s6_2q, c234c6_2q, c1c2_2q, s1c2_2q;
  pos_t  px2_q, py2_q, pz2_q;
  // stage 3
  trig_t u_q, v_q, c1c23_q, s1c23_q, c6_3q, s6_3q;
  trig_t c6c1s234_3q, s6c1s234_3q, c6s1s234_3q, s6s1s234_3q;
  wide_t r02_q, r12_q, r20_q, r21_q, r22_q;
  pos_t  px3_q, py3_q, pz3_q;
  // stage 4
  trig_t c6u_q, s6u_q, c6v_q, s6v_q;
  trig_t c6c1s234_4q, s6c1s234_4q, c6s1s234_4q, s6s1s234_4q;
  wide_t r02_4q, r12_4q, r20_4q, r21_4q, r22_4q;
  pos_t  px4_q, py4_q, pz4_q;
  // stage 5, output register
  logic signed [17:0] rot_q [9];
  logic signed [19:0] pos_q [3];

  assign s1   = sin_i[TrigQ1];
  assign c1   = cos_i[TrigQ1];
  assign s2   = sin_i[TrigQ2];
  assign c2   = cos_i[TrigQ2];
  assign s3   = sin_i[TrigQ3];
  assign c3   = cos_i[TrigQ3];
  assign s5   = sin_i[TrigQ5];
  assign c5   = cos_i[TrigQ5];
  assign s6   = sin_i[TrigQ6];
  assign c6   = cos_i[TrigQ6];
  assign s234 = sin_i[TrigQ234];
  assign c234 = cos_i[TrigQ234];

  // first-order products and base of the position sums
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c2c3_q   <= mul30(c2, c3);
      s2s3_q   <= mul30(s2, s3);
      s2c3_q   <= mul30(s2, c3);
      c2s3_q   <= mul30(c2, s3);
      c1s234_q <= mul30(c1, s234);
      s1s234_q <= mul30(s1, s234);
      c234s5_q <= mul30(c234, s5);
      s1s5_q   <= mul30(s1, s5);
      c1c234_q <= mul30(c1, c234);
      s1c234_q <= mul30(s1, c234);
      c1s5_q   <= mul30(c1, s5);
      c5s1_q   <= mul30(c5, s1);
      c1c5_q   <= mul30(c1, c5);
      s234s5_q <= mul30(s234, s5);
      c234s6_q <= mul30(c234, s6);
      c234c6_q <= mul30(c234, c6);
      s234c5_q <= mul30(s234, c5);
      c1c2_q   <= mul30(c1, c2);
      s1c2_q   <= mul30(s1, c2);
      c1_1q    <= c1;
      s1_1q    <= s1;
      c5_1q    <= c5;
      c6_1q    <= c6;
      s6_1q    <= s6;
      px1_q    <= lmul(d4_i, s1);
      py1_q    <= -lmul(d4_i, c1);
      pz1_q    <= (pos_t'(d1_i) <<< 30) + lmul(a2_i, s2) - lmul(d5_i, c234);
    end
  end

  // second-order products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c23_q      <= c2c3_q - s2s3_q;
      s23_q      <= s2c3_q + c2s3_q;
      ub_q       <= mul30(c1c234_q, c5_1q);
      va_q       <= mul30(s1c234_q, c5_1q);
      c1c234s5_q <= mul30(c1_1q, c234s5_q);
      s1c234s5_q <= mul30(s1_1q, c234s5_q);
      c6c1s234_q <= mul30(c6_1q, c1s234_q);
      s6c1s234_q <= mul30(s6_1q, c1s234_q);
      c6s1s234_q <= mul30(c6_1q, s1s234_q);
      s6s1s234_q <= mul30(s6_1q, s1s234_q);
      s234c5c6_q <= mul30(s234c5_q, c6_1q);
      s234c5s6_q <= mul30(s234c5_q, s6_1q);
      s1s5_2q    <= s1s5_q;
      c1s5_2q    <= c1s5_q;
      c6_2q      <= c6_1q;
      s6_2q      <= s6_1q;
      c1_2q      <= c1_1q;
      s1_2q      <= s1_1q;
      c5s1_2q    <= c5s1_q;
      c1c5_2q    <= c1c5_q;
      s234s5_2q  <= s234s5_q;
      c234s6_2q  <= c234s6_q;
      c234c6_2q  <= c234c6_q;
      c1c2_2q    <= c1c2_q;
      s1c2_2q    <= s1c2_q;
      px2_q      <= px1_q + lmul(d5_i, c1s234_q) + lmul(d6_i, c5s1_q);
      py2_q      <= py1_q + lmul(d5_i, s1s234_q) - lmul(d6_i, c1c5_q);
      pz2_q      <= pz1_q - lmul(d6_i, s234s5_q);
    end
  end

  // wrist terms and fixed rotation entries
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q         <= s1s5_2q + ub_q;
      v_q         <= va_q - c1s5_2q;
      c1c23_q     <= mul30(c1_2q, c23_q);
      s1c23_q     <= mul30(s1_2q, c23_q);
      c6_3q       <= c6_2q;
      s6_3q       <= s6_2q;
      c6c1s234_3q <= c6c1s234_q;
      s6c1s234_3q <= s6c1s234_q;
      c6s1s234_3q <= c6s1s234_q;
      s6s1s234_3q <= s6s1s234_q;
      r02_q       <= wide_t'(c5s1_2q) - wide_t'(c1c234s5_q);
      r12_q       <= -(wide_t'(c1c5_2q) + wide_t'(s1c234s5_q));
      r20_q       <= wide_t'(c234s6_2q) + wide_t'(s234c5c6_q);
      r21_q       <= wide_t'(c234c6_2q) - wide_t'(s234c5s6_q);
      r22_q       <= -wide_t'(s234s5_2q);
      px3_q       <= px2_q + lmul(a2_i, c1c2_2q) - lmul(d6_i, c1c234s5_q);
      py3_q       <= py2_q + lmul(a2_i, s1c2_2q) - lmul(d6_i, s1c234s5_q);
      pz3_q       <= pz2_q + lmul(a3_i, s23_q);
    end
  end

  // tool roll products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c6u_q       <= mul30(c6_3q, u_q);
      s6u_q       <= mul30(s6_3q, u_q);
      c6v_q       <= mul30(c6_3q, v_q);
      s6v_q       <= mul30(s6_3q, v_q);
      c6c1s234_4q <= c6c1s234_3q;
      s6c1s234_4q <= s6c1s234_3q;
      c6s1s234_4q <= c6s1s234_3q;
      s6s1s234_4q <= s6s1s234_3q;
      r02_4q      <= r02_q;
      r12_4q      <= r12_q;
      r20_4q      <= r20_q;
      r21_4q      <= r21_q;
      r22_4q      <= r22_q;
      px4_q       <= px3_q + lmul(a3_i, c1c23_q);
      py4_q       <= py3_q + lmul(a3_i, s1c23_q);
      pz4_q       <= pz3_q;
    end
  end

  // final sums, rounding and saturation
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q[0] <= rot_round(wide_t'(c6u_q) - wide_t'(s6c1s234_4q));
      rot_q[1] <= rot_round(-wide_t'(c6c1s234_4q) - wide_t'(s6u_q));
      rot_q[2] <= rot_round(r02_4q);
      rot_q[3] <= rot_round(wide_t'(c6v_q) - wide_t'(s6s1s234_4q));
      rot_q[4] <= rot_round(-wide_t'(c6s1s234_4q) - wide_t'(s6v_q));
      rot_q[5] <= rot_round(r12_4q);
      rot_q[6] <= rot_round(r20_4q);
      rot_q[7] <= rot_round(r21_4q);
      rot_q[8] <= rot_round(r22_4q);
      pos_q[0] <= pos_round(px4_q);
      pos_q[1] <= pos_round(py4_q);
      pos_q[2] <= pos_round(pz4_q);
    end
  end

  assign rot_o = rot_q;
  assign pos_o = pos_q;

endmodule

### sv/arm_forward_kinematics_6dof_top.sv
// throughput: one transaction per cycle, set by the fully pipelined cordic cell rows
// and the five-stage product pipeline; a stalled output stalls every stage together
// reset: valid pipeline cleared, link registers return to their default lengths
// ----------------------------------------------------------------------------
// arm_forward_kinematics_6dof_top
// six-axis arm forward kinematics: rotation matrix and tool position
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "arm_forward_kinematics_6dof_top_assert.svh"

module arm_forward_kinematics_6dof_top import armfk_pkg::*; #(
  parameter int CORDIC_STAGES = CordicStagesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [19:0] joint1_angle_i,
  input  logic signed [19:0] joint2_angle_i,
  input  logic signed [19:0] joint3_angle_i,
  input  logic signed [19:0] joint4_angle_i,
  input  logic signed [19:0] joint5_angle_i,
  input  logic signed [19:0] joint6_angle_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [17:0] rot_00_o,
  output logic signed [17:0] rot_01_o,
  output logic signed [17:0] rot_02_o,
  output logic signed [17:0] rot_10_o,
  output logic signed [17:0] rot_11_o,
  output logic signed [17:0] rot_12_o,
  output logic signed [17:0] rot_20_o,
  output logic signed [17:0] rot_21_o,
  output logic signed [17:0] rot_22_o,
  output logic signed [19:0] pos_x_o,
  output logic signed [19:0] pos_y_o,
  output logic signed [19:0] pos_z_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [17:0]        cfg_data_i
);

  localparam int Total = CORDIC_STAGES + SinCosExtra + KinLat;

  logic                   en;
  logic [Total-1:0]       vld_d, vld_q;
  logic signed [AngW-1:0] ang [TrigN];
  trig_t                  sin_v [TrigN];
  trig_t                  cos_v [TrigN];
  len_t                   d1_q, a2_q, a3_q, d4_q, d5_q, d6_q;
  logic signed [17:0]     rot [9];
  logic signed [19:0]     pos [3];

  // whole pipeline moves unless the result is held
  assign en          = !vld_q[Total-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[Total-1];
  assign cfg_ready_o = 1'b1;

  // link length registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_q <= 18'sd8343;
      a2_q <= -18'sd40108;
      a3_q <= -18'sd37506;
      d4_q <= 18'sd10744;
      d5_q <= 18'sd7583;
      d6_q <= 18'sd6042;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        RegBaseHeight: d1_q <= cfg_data_i;
        RegUpperArm:   a2_q <= cfg_data_i;
        RegForearm:    a3_q <= cfg_data_i;
        RegWrist1:     d4_q <= cfg_data_i;
        RegWrist2:     d5_q <= cfg_data_i;
        RegWrist3:     d6_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // valid tracking along the pipeline
  always_comb begin
    vld_d = vld_q;
    if (en) begin
      vld_d = {vld_q[Total-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // joint angles and the summed wrist pitch angle
  assign ang[TrigQ1]   = AngW'(joint1_angle_i);
  assign ang[TrigQ2]   = AngW'(joint2_angle_i);
  assign ang[TrigQ3]   = AngW'(joint3_angle_i);
  assign ang[TrigQ5]   = AngW'(joint5_angle_i);
  assign ang[TrigQ6]   = AngW'(joint6_angle_i);
  assign ang[TrigQ234] = AngW'(joint2_angle_i) + AngW'(joint3_angle_i)
                       + AngW'(joint4_angle_i);

  // one sine/cosine pipeline per angle
  for (genvar j = 0; j < TrigN; j++) begin : g_sc
    armfk_sincos #(
      .CORDIC_STAGES(CORDIC_STAGES)
    ) u_sincos (
      .clk_i  (clk_i),
      .en_i   (en),
      .angle_i(ang[j]),
      .sin_o  (sin_v[j]),
      .cos_o  (cos_v[j])
    );
  end

  armfk_kin u_kin (
    .clk_i(clk_i),
    .en_i (en),
    .sin_i(sin_v),
    .cos_i(cos_v),
    .d1_i (d1_q),
    .a2_i (a2_q),
    .a3_i (a3_q),
    .d4_i (d4_q),
    .d5_i (d5_q),
    .d6_i (d6_q),
    .rot_o(rot),
    .pos_o(pos)
  );

  assign rot_00_o = rot[0];
  assign rot_01_o = rot[1];
  assign rot_02_o = rot[2];
  assign rot_10_o = rot[3];
  assign rot_11_o = rot[4];
  assign rot_12_o = rot[5];
  assign rot_20_o = rot[6];
  assign rot_21_o = rot[7];
  assign rot_22_o = rot[8];
  assign pos_x_o  = pos[0];
  assign pos_y_o  = pos[1];
  assign pos_z_o  = pos[2];

  // checks
  `ARMFK_ASSERT_ALWAYS(a_rst_no_result, !rst_ni |-> !out_valid_o)
  `ARMFK_ASSERT(a_drain, (en && !vld_q[Total-2]) |=> !out_valid_o)
  `ARMFK_ASSERT(a_rot_sat, out_valid_o |-> (rot_22_o <= 18'sd65536 && rot_22_o >= -18'sd65536))
  `ARMFK_ASSERT(a_pos_sat, out_valid_o |-> (pos_z_o <= 20'sd262144 && pos_z_o >= -20'sd262144))

endmodule
